### sv/cpwmdt_pkg.sv
// Shared types, register codes and the duty scaling table for the
// complementary PWM dead-time unit. No dependencies.
package cpwmdt_pkg;

   localparam int unsigned COMPARE_W = 16;
   localparam int unsigned DT_W      = 10;
   localparam int unsigned RECIP_W   = 24;
   localparam int unsigned RECIP_SH  = 23;
   localparam int unsigned DUTY_MAX  = 100;

   localparam logic [15:0] PERIOD_TOP_RST   = 16'd170;
   localparam logic [15:0] COUNTER_START_RST = 16'd0;
   localparam logic [1:0]  DT_PRESCALE_RST  = 2'd2;
   localparam logic [5:0]  DT_COUNT_RST     = 6'd3;
   localparam logic        DT_ENABLE_RST    = 1'b1;
   localparam logic        COMP_ENABLE_RST  = 1'b1;

   localparam logic [2:0] CSR_PERIOD_TOP    = 3'd0;
   localparam logic [2:0] CSR_COUNTER_START = 3'd1;
   localparam logic [2:0] CSR_DT_PRESCALE   = 3'd2;
   localparam logic [2:0] CSR_DT_COUNT      = 3'd3;
   localparam logic [2:0] CSR_DT_ENABLE     = 3'd4;
   localparam logic [2:0] CSR_COMP_ENABLE   = 3'd5;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_DUTY = 1'b1;

   localparam logic [1:0] PRESCALE_DIV4  = 2'd2;
   localparam logic [1:0] PRESCALE_DIV16 = 2'd3;

   typedef struct packed {
      logic [15:0] period_top;
      logic [15:0] counter_start;
      logic [1:0]  deadtime_prescale;
      logic [5:0]  deadtime_count;
      logic        deadtime_enable;
      logic        complementary_enable;
   } cfg_type;

   typedef struct packed {
      logic        chan_high_out;
      logic        chan_low_out;
      logic [15:0] count_value;
      logic        reload_done;
   } result_type;

   typedef logic [RECIP_W-1:0] recip_tab_type [0:DUTY_MAX];

   // ceil(p * 2^23 / 100): top * entry >> 23 equals floor(p * top / 100)
   // exactly for any 16-bit top.
   function automatic recip_tab_type build_recip();
      recip_tab_type   tab;
      longint unsigned v;
      for (int i = 0; i <= DUTY_MAX; i++) begin
         v      = ((longint'(i) << RECIP_SH) + longint'(DUTY_MAX - 1)) / DUTY_MAX;
         tab[i] = RECIP_W'(v);
      end
      return tab;
   endfunction

   localparam recip_tab_type RECIP_TABLE = build_recip();

endpackage

### sv/complementary_pwm_deadtime_unit.sv
// Complementary edge-aligned PWM timer with dead-time insertion, top level.
// Path: a request accepted into the input register moves on into the result
// register, which drives rsp_, once that register is empty or being taken.
// Throughput: one request per cycle; the input and result registers decouple
// the channels, so req_ready only drops when both hold requests and rsp stalls.
// Reset (synchronous): counter at start value, compares and hold cleared,
// configuration registers at their default values.
module complementary_pwm_deadtime_unit #(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [6:0]  req_duty_percent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_chan_high_out,
   output logic        rsp_chan_low_out,
   output logic [15:0] rsp_count_value,
   output logic        rsp_reload_done,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import cpwmdt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       req_valid_ff, req_valid_in;
   logic       req_func_ff;
   logic [6:0] req_duty_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type core_res;
   logic       advance, req_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PERIOD_TOP:    cfg_in.period_top           = csr_write_data;
            CSR_COUNTER_START: cfg_in.counter_start        = csr_write_data;
            CSR_DT_PRESCALE:   cfg_in.deadtime_prescale    = csr_write_data[1:0];
            CSR_DT_COUNT:      cfg_in.deadtime_count       = csr_write_data[5:0];
            CSR_DT_ENABLE:     cfg_in.deadtime_enable      = csr_write_data[0];
            CSR_COMP_ENABLE:   cfg_in.complementary_enable = csr_write_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !req_valid_ff || advance;
      req_take  = req_valid && req_ready;

      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   cpwmdt_core #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .func         (req_func_ff),
      .duty_percent (req_duty_ff),
      .cfg          (cfg_ff),
      .res          (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_top           <= PERIOD_TOP_RST;
         cfg_ff.counter_start        <= COUNTER_START_RST;
         cfg_ff.deadtime_prescale    <= DT_PRESCALE_RST;
         cfg_ff.deadtime_count       <= DT_COUNT_RST;
         cfg_ff.deadtime_enable      <= DT_ENABLE_RST;
         cfg_ff.complementary_enable <= COMP_ENABLE_RST;
         req_valid_ff                <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_func_ff <= req_func;
         req_duty_ff <= req_duty_percent;
      end
      if (advance) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chan_high_out = rsp_data_ff.chan_high_out;
   assign rsp_chan_low_out  = rsp_data_ff.chan_low_out;
   assign rsp_count_value   = rsp_data_ff.count_value;
   assign rsp_reload_done   = rsp_data_ff.reload_done;

endmodule

### sv/cpwmdt_duty_scale.sv
// Duty request scaling: compare = min(percent,100) * top / 100.
// Uses the reciprocal table from cpwmdt_pkg; one 16x24 multiply.
module cpwmdt_duty_scale (
   input  logic [6:0]  duty_percent,
   input  logic [15:0] period_top,
   output logic [15:0] duty_compare
);
   import cpwmdt_pkg::*;

   logic [6:0]                pct_clip;
   logic [RECIP_W-1:0]        recip;
   logic [RECIP_W+15:0]       product;

   always_comb begin
      pct_clip     = (duty_percent > 7'(DUTY_MAX)) ? 7'(DUTY_MAX) : duty_percent;
      recip        = RECIP_TABLE[pct_clip];
      product      = (RECIP_W+16)'(period_top) * (RECIP_W+16)'(recip);
      duty_compare = product[RECIP_SH+15:RECIP_SH];
   end

endmodule

### sv/cpwmdt_core.sv
// Timer state: period counter, compare buffering, dead-time hold, channel levels.
// Depends on cpwmdt_pkg and cpwmdt_duty_scale.
module cpwmdt_core #(
   parameter int unsigned COUNTER_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   func,
   input  logic [6:0]             duty_percent,
   input  cpwmdt_pkg::cfg_type    cfg,
   output cpwmdt_pkg::result_type res
);
   import cpwmdt_pkg::*;

   localparam int unsigned CW    = COUNTER_WIDTH;
   localparam int unsigned CMP_W = (CW > COMPARE_W) ? CW : COMPARE_W;

   logic [CW-1:0]        counter_ff, counter_in;
   logic [COMPARE_W-1:0] active_ff, active_in;
   logic [COMPARE_W-1:0] pending_ff, pending_in;
   logic                 pending_valid_ff, pending_valid_in;
   logic [DT_W-1:0]      remaining_ff, remaining_in;
   logic                 raw_prev_ff, raw_prev_in;

   logic [COMPARE_W-1:0] duty_compare;
   logic [CW-1:0]        top_cw, start_cw, counter_next;
   logic                 at_top, reload, raw;
   logic [COMPARE_W-1:0] active_next;
   logic [DT_W-1:0]      hold_len, remaining_next;
   logic                 held;

   cpwmdt_duty_scale u_duty_scale (
      .duty_percent (duty_percent),
      .period_top   (cfg.period_top),
      .duty_compare (duty_compare)
   );

   always_comb begin
      unique case (cfg.deadtime_prescale)
         PRESCALE_DIV4:  hold_len = DT_W'({cfg.deadtime_count, 2'b00});
         PRESCALE_DIV16: hold_len = DT_W'({cfg.deadtime_count, 4'b0000});
         default:        hold_len = DT_W'(cfg.deadtime_count);
      endcase

      top_cw       = CW'(cfg.period_top);
      start_cw     = CW'(cfg.counter_start);
      at_top       = (counter_ff == top_cw);
      counter_next = at_top ? start_cw : counter_ff + CW'(1);
      reload       = at_top && pending_valid_ff;
      active_next  = reload ? pending_ff : active_ff;
      raw          = CMP_W'(counter_next) < CMP_W'(active_next);

      if (!cfg.deadtime_enable) begin
         remaining_next = '0;
      end else if (raw != raw_prev_ff) begin
         remaining_next = hold_len;
      end else if (remaining_ff != '0) begin
         remaining_next = remaining_ff - DT_W'(1);
      end else begin
         remaining_next = remaining_ff;
      end

      counter_in       = counter_ff;
      active_in        = active_ff;
      pending_in       = pending_ff;
      pending_valid_in = pending_valid_ff;
      remaining_in     = remaining_ff;
      raw_prev_in      = raw_prev_ff;
      if (step) begin
         unique case (func)
            FUNC_DUTY: begin
               pending_in       = duty_compare;
               pending_valid_in = 1'b1;
            end
            default: begin
               counter_in       = counter_next;
               active_in        = active_next;
               pending_valid_in = pending_valid_ff && !at_top;
               remaining_in     = remaining_next;
               raw_prev_in      = raw;
            end
         endcase
      end

      // result reflects the state after this request
      held              = cfg.deadtime_enable && (remaining_in != '0);
      res.chan_high_out = !held && raw_prev_in;
      res.chan_low_out  = !held && (cfg.complementary_enable ? !raw_prev_in : raw_prev_in);
      res.count_value   = 16'(counter_in);
      res.reload_done   = (func == FUNC_TICK) && reload;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff       <= CW'(COUNTER_START_RST);
         active_ff        <= '0;
         pending_ff       <= '0;
         pending_valid_ff <= 1'b0;
         remaining_ff     <= '0;
         raw_prev_ff      <= 1'b0;
      end else begin
         counter_ff       <= counter_in;
         active_ff        <= active_in;
         pending_ff       <= pending_in;
         pending_valid_ff <= pending_valid_in;
         remaining_ff     <= remaining_in;
         raw_prev_ff      <= raw_prev_in;
      end
   end

   a_reload_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (step && res.reload_done) |=> !pending_valid_ff)
      else $error("pending compare still valid after reload");

   a_never_both_high: assert property (@(posedge clock) disable iff (reset)
      cfg.complementary_enable |-> !(res.chan_high_out && res.chan_low_out))
      else $error("both channels high in complementary mode");

   a_counter_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(counter_ff) && $stable(remaining_ff))
      else $error("timer state moved without a request");

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      remaining_ff <= DT_W'(1008))
      else $error("dead-time hold beyond maximum length");

   a_dt_off_clears: assert property (@(posedge clock) disable iff (reset)
      (step && func == FUNC_TICK && !cfg.deadtime_enable) |=> remaining_ff == '0)
      else $error("hold not cleared with dead time disabled");

endmodule

### tb/sv/tb_complementary_pwm_deadtime_unit.sv
// Self-checking bench for complementary_pwm_deadtime_unit: directed table, then
// randomized phases that each set the registers and stream requests.
// Depends on cpwmdt_pkg and the unit itself.
module tb_complementary_pwm_deadtime_unit;
   import cpwmdt_pkg::*;

   localparam int DIRECTED_LEN    = 37;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 55;

   typedef enum int {SPAN_NEAR, SPAN_WRAPPED, SPAN_TOP_ZERO} span_mode_type;

   typedef struct {
      bit          is_reg;
      logic [2:0]  reg_index;
      logic [15:0] reg_value;
      logic        func;
      logic [6:0]  percent;
      bit          typed;
      result_type  want;
   } step_row_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_func         = FUNC_TICK;
   logic [6:0]  req_duty_percent = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic        rsp_chan_high_out;
   logic        rsp_chan_low_out;
   logic [15:0] rsp_count_value;
   logic        rsp_reload_done;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index        = '0;
   logic [15:0] csr_write_data   = '0;

   complementary_pwm_deadtime_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_duty_percent  (req_duty_percent),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_chan_high_out (rsp_chan_high_out),
      .rsp_chan_low_out  (rsp_chan_low_out),
      .rsp_count_value   (rsp_count_value),
      .rsp_reload_done   (rsp_reload_done),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // timer model state
   cfg_type     pwm_cfg;
   logic [15:0] pwm_count;
   logic [15:0] cmp_active;
   logic [15:0] cmp_pending;
   logic        cmp_pending_valid;
   logic [9:0]  hold_left;
   logic        raw_prev;

   result_type   expected_levels [$];
   int           mismatch_count  = 0;
   bit           quiet           = 1'b0;
   int           hold_cycles_req = 0;
   step_row_type directed_steps [DIRECTED_LEN];

   function automatic result_type predict_pwm(logic f, logic [6:0] p);
      result_type r;
      logic [6:0] pct;
      logic [9:0] span;
      logic       raw;
      logic       held;
      r.reload_done = 1'b0;
      if (f == FUNC_DUTY) begin
         pct = (p > 7'd100) ? 7'd100 : p;
         cmp_pending       = 16'((32'(pct) * 32'(pwm_cfg.period_top)) / 32'd100);
         cmp_pending_valid = 1'b1;
      end else begin
         if (pwm_count == pwm_cfg.period_top) begin
            pwm_count = pwm_cfg.counter_start;
            if (cmp_pending_valid) begin
               cmp_active        = cmp_pending;
               cmp_pending_valid = 1'b0;
               r.reload_done     = 1'b1;
            end
         end else begin
            pwm_count = pwm_count + 16'd1;
         end
         raw = pwm_count < cmp_active;
         case (pwm_cfg.deadtime_prescale)
            PRESCALE_DIV4:  span = 10'(pwm_cfg.deadtime_count) << 2;
            PRESCALE_DIV16: span = 10'(pwm_cfg.deadtime_count) << 4;
            default:        span = 10'(pwm_cfg.deadtime_count);
         endcase
         if (!pwm_cfg.deadtime_enable) hold_left = '0;
         else if (raw != raw_prev) hold_left = span;
         else if (hold_left != '0) hold_left = hold_left - 10'd1;
         raw_prev = raw;
      end
      held = pwm_cfg.deadtime_enable && (hold_left != '0);
      r.chan_high_out = held ? 1'b0 : raw_prev;
      r.chan_low_out  = held ? 1'b0 : (pwm_cfg.complementary_enable ? ~raw_prev : raw_prev);
      r.count_value   = pwm_count;
      return r;
   endfunction

   function automatic step_row_type row_item(logic f, logic [6:0] p, bit typed,
                                             result_type want);
      step_row_type r;
      r.is_reg    = 1'b0;
      r.reg_index = '0;
      r.reg_value = '0;
      r.func      = f;
      r.percent   = p;
      r.typed     = typed;
      r.want      = want;
      return r;
   endfunction

   function automatic step_row_type row_reg(logic [2:0] idx, logic [15:0] val);
      step_row_type r;
      r           = row_item(FUNC_TICK, '0, 1'b0, '0);
      r.is_reg    = 1'b1;
      r.reg_index = idx;
      r.reg_value = val;
      return r;
   endfunction

   function automatic cfg_type pick_config(span_mode_type m, int ph);
      cfg_type     c;
      int unsigned span;
      int          t;
      span = $urandom_range(1, 40);
      case (m)
         SPAN_NEAR: begin
            if (pwm_count > 16'd65400) begin
               if ($urandom_range(0, 1) == 0) begin
                  c.period_top    = 16'hFFFF;
                  c.counter_start = 16'hFFFF - 16'($urandom_range(0, 30));
               end else begin
                  // top lowered below the counter: it runs through the 16-bit wrap
                  c.period_top    = 16'($urandom_range(1, 30));
                  c.counter_start = 16'($urandom_range(0, c.period_top));
               end
            end else begin
               t = int'(pwm_count) + int'(span);
               if (t > 65535) t = 65535;
               c.period_top    = 16'(t);
               c.counter_start = 16'(t - int'($urandom_range(0, span)));
            end
         end
         SPAN_WRAPPED: begin
            c.period_top    = pwm_count;
            c.counter_start = 16'hFFFF - 16'($urandom_range(0, 30));
         end
         default: begin
            c.period_top    = pwm_count;
            c.counter_start = 16'hFFFF - 16'($urandom_range(0, 6));
         end
      endcase
      c.deadtime_prescale = 2'(ph % 4);
      case (ph % 3)
         0:       c.deadtime_count = 6'($urandom_range(1, 8));
         1:       c.deadtime_count = (ph % 2 == 1) ? 6'd63 : 6'd0;
         default: c.deadtime_count = 6'($urandom_range(0, 63));
      endcase
      c.deadtime_enable      = (ph == 6) ? 1'b0 : ($urandom_range(0, 99) < 85);
      c.complementary_enable = 1'($urandom_range(0, 1));
      return c;
   endfunction

   task automatic note_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task automatic send_request(logic f, logic [6:0] p, bit typed, result_type want);
      result_type guess;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= f;
      req_duty_percent <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_pwm(f, p);
      expected_levels.push_back(typed ? want : guess);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_PERIOD_TOP:    pwm_cfg.period_top           = val;
         CSR_COUNTER_START: pwm_cfg.counter_start        = val;
         CSR_DT_PRESCALE:   pwm_cfg.deadtime_prescale    = val[1:0];
         CSR_DT_COUNT:      pwm_cfg.deadtime_count       = val[5:0];
         CSR_DT_ENABLE:     pwm_cfg.deadtime_enable      = val[0];
         CSR_COMP_ENABLE:   pwm_cfg.complementary_enable = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_levels.size() == 0) begin
            note_mismatch("result with no request outstanding");
         end else begin
            want = expected_levels.pop_front();
            compare_field("chan_high_out", 16'(rsp_chan_high_out), 16'(want.chan_high_out));
            compare_field("chan_low_out", 16'(rsp_chan_low_out), 16'(want.chan_low_out));
            compare_field("count_value", rsp_count_value, want.count_value);
            compare_field("reload_done", 16'(rsp_reload_done), 16'(want.reload_done));
         end
      end
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles_req != 0) begin
            stall_left      = hold_cycles_req;
            hold_cycles_req = 0;
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= quiet || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   initial begin : stimulus
      cfg_type       c;
      span_mode_type mode;
      logic          f;
      logic [6:0]    pct;

      pwm_cfg = '{PERIOD_TOP_RST, COUNTER_START_RST, DT_PRESCALE_RST, DT_COUNT_RST,
                  DT_ENABLE_RST, COMP_ENABLE_RST};
      pwm_count         = COUNTER_START_RST;
      cmp_active        = '0;
      cmp_pending       = '0;
      cmp_pending_valid = 1'b0;
      hold_left         = '0;
      raw_prev          = 1'b0;

      directed_steps = '{
         row_item(FUNC_DUTY, 7'd0,   1'b1, {1'b0, 1'b1, 16'd0, 1'b0}),
         row_item(FUNC_TICK, 7'd0,   1'b1, {1'b0, 1'b1, 16'd1, 1'b0}),
         row_item(FUNC_DUTY, 7'd127, 1'b1, {1'b0, 1'b1, 16'd1, 1'b0}),
         row_item(FUNC_DUTY, 7'd101, 1'b0, '0),
         // compare stays scaled to the old top after top shrinks
         row_reg(CSR_PERIOD_TOP, 16'd4),
         row_reg(CSR_COUNTER_START, 16'd1),
         row_reg(CSR_DT_PRESCALE, 16'd0),
         row_reg(CSR_DT_COUNT, 16'd2),
         row_item(FUNC_TICK, 7'h7F, 1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_DUTY, 7'd50, 1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         // hold longer than the pulse: edges land inside a running hold
         row_reg(CSR_DT_PRESCALE, 16'(PRESCALE_DIV4)),
         row_reg(CSR_DT_COUNT, 16'd1),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_reg(CSR_DT_COUNT, 16'd0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_reg(CSR_DT_ENABLE, 16'd0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_reg(CSR_COMP_ENABLE, 16'd0),
         row_reg(CSR_DT_ENABLE, 16'd1),
         row_reg(CSR_DT_COUNT, 16'd2),
         row_reg(CSR_DT_PRESCALE, 16'(PRESCALE_DIV16)),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_TICK, 7'd0,  1'b0, '0),
         row_item(FUNC_DUTY, 7'd0,  1'b0, '0)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_reg) begin
            settle();
            write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
         end else begin
            send_request(directed_steps[i].func, directed_steps[i].percent,
                         directed_steps[i].typed, directed_steps[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         if (ph % 4 == 2) mode = SPAN_WRAPPED;
         else if (ph % 4 == 0 && ph != 0) mode = SPAN_TOP_ZERO;
         else mode = SPAN_NEAR;
         c = pick_config(mode, ph);
         write_reg(CSR_PERIOD_TOP, c.period_top);
         write_reg(CSR_COUNTER_START, c.counter_start);
         write_reg(CSR_DT_PRESCALE, 16'(c.deadtime_prescale));
         write_reg(CSR_DT_COUNT, 16'(c.deadtime_count));
         write_reg(CSR_DT_ENABLE, 16'(c.deadtime_enable));
         write_reg(CSR_COMP_ENABLE, 16'(c.complementary_enable));
         if (mode == SPAN_TOP_ZERO) begin
            // one tick moves the counter to start, then top drops to zero
            send_request(FUNC_TICK, 7'd0, 1'b0, '0);
            settle();
            write_reg(CSR_PERIOD_TOP, 16'd0);
         end
         quiet = (ph == 5);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (ph == 3 && k == 10) begin
               quiet           = 1'b1;
               hold_cycles_req = 80;
            end
            if (ph == 3 && k == 40) quiet = 1'b0;
            f = ($urandom_range(0, 99) < 25) ? FUNC_DUTY : FUNC_TICK;
            case ($urandom_range(0, 7))
               0:       pct = 7'd0;
               1:       pct = 7'd100;
               2:       pct = 7'd101;
               3:       pct = 7'd127;
               default: pct = 7'($urandom_range(0, 127));
            endcase
            send_request(f, pct, 1'b0, '0);
         end
         quiet = 1'b0;
      end

      settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** complementary_pwm_deadtime_unit: PASSED **");
      end else begin
         $display("** complementary_pwm_deadtime_unit: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("** complementary_pwm_deadtime_unit: FAILED **");
      $finish;
   end

endmodule

### filelist.f
sv/cpwmdt_pkg.sv
sv/cpwmdt_duty_scale.sv
sv/cpwmdt_core.sv
sv/complementary_pwm_deadtime_unit.sv
tb/sv/tb_complementary_pwm_deadtime_unit.sv
